// ----- src/peer_exit_handshake_macros.svh -----
// Assertion macros for the RTL of the exit handshake block; only peh_back.sv includes them.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef PEER_EXIT_HANDSHAKE_MACROS_SVH
`define PEER_EXIT_HANDSHAKE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PEH_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define PEH_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PEH_AST_IMP(lbl, ante, cons, msg)
`define PEH_AST_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- src/peh_pkg.sv -----
package peh_pkg;

	// Default topology limits and fixed sizes.
	localparam int MAX_NODES_DEF   = 8;
	localparam int MAX_SOCKETS_DEF = 4;
	localparam int MAX_ACTIONS     = 31;
	localparam int QDEPTH          = 2;

	typedef enum logic [1:0] {
		PH_RUN    = 2'd0,
		PH_WAIT   = 2'd1,
		PH_QUIET  = 2'd2,
		PH_CLOSED = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_NOTIFY = 2'd0,
		KIND_ACK    = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		MODE_START  = 3'd0,
		MODE_NOTIFY = 3'd1,
		MODE_ACK    = 3'd2,
		MODE_PUMP   = 3'd3,
		MODE_FINAL  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		EV_START,
		EV_NOTIFY,
		EV_ACK,
		EV_PUMP,
		EV_FINAL,
		EV_NONE
	} ev_t;

	typedef enum logic [2:0] {
		CFG_NODE_COUNT   = 3'd0,
		CFG_SOCKET_COUNT = 3'd1,
		CFG_OWN_NODE     = 3'd2,
		CFG_OWN_SOCKET   = 3'd3,
		CFG_RETRY        = 3'd4,
		CFG_QUIESCE      = 3'd5,
		CFG_EXIT_NONCE   = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_WALK_START,
		BS_PUMP_RD,
		BS_PUMP_CMP,
		BS_NOTIFY,
		BS_NOTIFY2,
		BS_ACK,
		BS_UPD1,
		BS_UPD2,
		BS_STATUS
	} bs_t;

	// Effective configuration seen by both front and back.
	typedef struct packed {
		logic [3:0]  eff_nodes;
		logic [2:0]  eff_sockets;
		logic [2:0]  own_node;
		logic [1:0]  own_socket;
		logic [31:0] retry;
		logic [31:0] quiesce;
		logic [31:0] own_id;
	} cfg_t;

	// One classified request waiting in the queue.
	typedef struct packed {
		ev_t         ev;
		logic [2:0]  pn;
		logic [1:0]  ps;
		logic [31:0] eid;
		logic [63:0] now;
		logic [63:0] rsum;
		logic [63:0] qsum;
		logic        peer_valid;
		logic        peer_self;
		logic        eid_zero;
		logic        eid_own;
	} q_item_t;

	// Saturating 64-bit time sum.
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {33'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

// ----- src/peh_ram.sv -----
module peh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/peh_front.sv -----
module peh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  peh_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        mode,
	input  logic [2:0]        peer_node,
	input  logic [1:0]        peer_socket,
	input  logic [31:0]       exit_id_in,
	input  logic [63:0]       now_ms,
	output logic              q_valid,
	output peh_pkg::q_item_t  q_item,
	input  logic              q_pop
);
	import peh_pkg::*;

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	q_item_t        mem_q [QDEPTH];
	q_item_t        item;
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;
	logic           push;

	// Classify the incoming request and precompute its deadlines.
	always_comb begin
		unique case (mode)
			MODE_START:  item.ev = EV_START;
			MODE_NOTIFY: item.ev = EV_NOTIFY;
			MODE_ACK:    item.ev = EV_ACK;
			MODE_PUMP:   item.ev = EV_PUMP;
			MODE_FINAL:  item.ev = EV_FINAL;
			default:     item.ev = EV_NONE;
		endcase
		item.pn         = peer_node;
		item.ps         = peer_socket;
		item.eid        = exit_id_in;
		item.now        = now_ms;
		item.rsum       = sat_add(now_ms, cfg.retry);
		item.qsum       = sat_add(now_ms, cfg.quiesce);
		item.peer_valid = ({1'b0, peer_node} < cfg.eff_nodes) &&
			({1'b0, peer_socket} < cfg.eff_sockets);
		item.peer_self  = (peer_node == cfg.own_node) && (peer_socket == cfg.own_socket);
		item.eid_zero   = (exit_id_in == 32'd0);
		item.eid_own    = (exit_id_in == cfg.own_id);
	end

	assign in_stall = (cnt_q == QCW'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rp_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (q_pop) begin
				rp_q <= (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- src/peh_back.sv -----
`include "peer_exit_handshake_macros.svh"
module peh_back #(
	parameter int MAX_NODES   = peh_pkg::MAX_NODES_DEF,
	parameter int MAX_SOCKETS = peh_pkg::MAX_SOCKETS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  peh_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  peh_pkg::q_item_t  q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        kind,
	output logic [2:0]        dest_node,
	output logic [1:0]        dest_socket,
	output logic [31:0]       exit_id_out,
	output logic [1:0]        phase,
	output logic              close_ready,
	output logic              finalize_ok,
	output logic              callback_fire,
	output logic              last
);
	import peh_pkg::*;

	localparam int PEERS = MAX_NODES * MAX_SOCKETS;
	localparam int PW    = (PEERS > 1) ? $clog2(PEERS) : 1;

	bs_t             state_q, state_d;
	q_item_t         cur_q;
	phase_t          phase_q;
	logic [PEERS-1:0] req_q, ack_q, seen_q;
	logic [63:0]     qd_q, qnb_q;
	logic            cr_q, cb_q, fin_q, fire_q;
	logic [PW-1:0]   idx_q, cur_idx;
	logic [3:0]      node_q;
	logic [1:0]      sock_q;
	logic [4:0]      acnt_q;
	logic            ov_q;
	logic [63:0]     rdata;

	// Control strobes from the sequencer.
	logic        take, walk_clr, step, emit, emit_act, ram_we;
	logic        set_req, set_seen, set_ack, upd_qnb, upd_qd_n, upd_quiet, upd_cr;
	logic        set_wait, do_final;
	kind_t       e_kind;
	logic [2:0]  e_node;
	logic [1:0]  e_sock;
	logic [31:0] e_eid;

	// Derived per-cycle conditions.
	logic out_free, idx_last, in_range, is_own, start_hit, pend_i, cap_ok, pending;

	assign out_free  = !ov_q || !out_stall;
	assign idx_last  = (idx_q == PW'(PEERS - 1));
	assign in_range  = (node_q < cfg.eff_nodes) && ({1'b0, sock_q} < cfg.eff_sockets);
	assign is_own    = (node_q == {1'b0, cfg.own_node}) && (sock_q == cfg.own_socket);
	assign start_hit = in_range && !is_own && !seen_q[idx_q];
	assign pend_i    = req_q[idx_q] && !ack_q[idx_q];
	assign cap_ok    = (acnt_q < 5'(MAX_ACTIONS));
	assign pending   = |(req_q & ~ack_q);
	assign cur_idx   = PW'(int'(cur_q.pn) * MAX_SOCKETS + int'(cur_q.ps));

	// Retry deadlines, one entry per peer.
	peh_ram #(.WIDTH(64), .DEPTH(PEERS)) u_retry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (cur_q.rsum),
		.raddr (idx_q),
		.rdata (rdata)
	);

	// Sequencer: next state and strobes.
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		take      = 1'b0;
		walk_clr  = 1'b0;
		step      = 1'b0;
		emit      = 1'b0;
		emit_act  = 1'b0;
		ram_we    = 1'b0;
		set_req   = 1'b0;
		set_seen  = 1'b0;
		set_ack   = 1'b0;
		upd_qnb   = 1'b0;
		upd_qd_n  = 1'b0;
		upd_quiet = 1'b0;
		upd_cr    = 1'b0;
		set_wait  = 1'b0;
		do_final  = 1'b0;
		e_kind    = KIND_STATUS;
		e_node    = '0;
		e_sock    = '0;
		e_eid     = '0;
		unique case (state_q)
			BS_IDLE: begin
				if (q_valid) begin
					q_pop    = 1'b1;
					take     = 1'b1;
					walk_clr = 1'b1;
					unique case (q_item.ev)
						EV_START:  state_d = (phase_q == PH_RUN) ? BS_WALK_START : BS_STATUS;
						EV_NOTIFY: state_d = ((phase_q != PH_CLOSED) && q_item.peer_valid &&
							!q_item.peer_self && !q_item.eid_zero) ? BS_NOTIFY : BS_STATUS;
						EV_ACK:    state_d = BS_ACK;
						EV_PUMP:   state_d = (phase_q == PH_WAIT) ? BS_PUMP_RD : BS_UPD1;
						EV_FINAL: begin
							do_final = cr_q && (phase_q == PH_QUIET);
							state_d  = BS_STATUS;
						end
						default:   state_d = BS_STATUS;
					endcase
				end
			end
			BS_WALK_START: begin
				if (out_free) begin
					step = 1'b1;
					if (start_hit) begin
						set_req = 1'b1;
						ram_we  = 1'b1;
						if (cap_ok) begin
							emit     = 1'b1;
							emit_act = 1'b1;
							e_kind   = KIND_NOTIFY;
							e_node   = node_q[2:0];
							e_sock   = sock_q;
							e_eid    = cfg.own_id;
						end
					end
					if (idx_last) begin
						set_wait = 1'b1;
						state_d  = BS_UPD1;
					end
				end
			end
			BS_PUMP_RD: begin
				if (pend_i) begin
					state_d = BS_PUMP_CMP;
				end else begin
					step    = 1'b1;
					state_d = idx_last ? BS_UPD1 : BS_PUMP_RD;
				end
			end
			BS_PUMP_CMP: begin
				if (cur_q.now >= rdata) begin
					if (out_free) begin
						ram_we = 1'b1;
						step   = 1'b1;
						if (cap_ok) begin
							emit     = 1'b1;
							emit_act = 1'b1;
							e_kind   = KIND_NOTIFY;
							e_node   = node_q[2:0];
							e_sock   = sock_q;
							e_eid    = cfg.own_id;
						end
						state_d = idx_last ? BS_UPD1 : BS_PUMP_RD;
					end
				end else begin
					step    = 1'b1;
					state_d = idx_last ? BS_UPD1 : BS_PUMP_RD;
				end
			end
			BS_NOTIFY: begin
				if (out_free) begin
					emit     = 1'b1;
					e_kind   = KIND_ACK;
					e_node   = cur_q.pn;
					e_sock   = cur_q.ps;
					e_eid    = cur_q.eid;
					set_seen = 1'b1;
					upd_qnb  = 1'b1;
					state_d  = BS_NOTIFY2;
				end
			end
			BS_NOTIFY2: begin
				upd_qd_n = (phase_q == PH_QUIET);
				state_d  = BS_UPD1;
			end
			BS_ACK: begin
				set_ack = (phase_q == PH_WAIT) && cur_q.eid_own && cur_q.peer_valid &&
					req_q[cur_idx];
				state_d = BS_UPD1;
			end
			BS_UPD1: begin
				upd_quiet = (phase_q == PH_WAIT) && !pending;
				state_d   = BS_UPD2;
			end
			BS_UPD2: begin
				upd_cr  = 1'b1;
				state_d = BS_STATUS;
			end
			BS_STATUS: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_STATUS;
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Exit protocol state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RUN;
			req_q   <= '0;
			ack_q   <= '0;
			seen_q  <= '0;
			qd_q    <= '0;
			qnb_q   <= '0;
			cr_q    <= 1'b0;
			cb_q    <= 1'b0;
			fin_q   <= 1'b0;
			fire_q  <= 1'b0;
		end else begin
			if (take) begin
				fin_q  <= 1'b0;
				fire_q <= 1'b0;
			end
			if (set_req) begin
				req_q[idx_q] <= 1'b1;
			end
			if (set_wait) begin
				phase_q <= PH_WAIT;
			end
			if (set_seen) begin
				seen_q[cur_idx] <= 1'b1;
			end
			if (set_ack) begin
				ack_q[cur_idx] <= 1'b1;
			end
			if (upd_qnb && (cur_q.qsum > qnb_q)) begin
				qnb_q <= cur_q.qsum;
			end
			if (upd_qd_n && (qnb_q > qd_q)) begin
				qd_q <= qnb_q;
			end
			if (upd_quiet) begin
				phase_q <= PH_QUIET;
				qd_q    <= (qnb_q > cur_q.qsum) ? qnb_q : cur_q.qsum;
			end
			if (upd_cr) begin
				cr_q <= (phase_q == PH_QUIET) && (cur_q.now >= qd_q);
			end
			if (do_final) begin
				phase_q <= PH_CLOSED;
				cr_q    <= 1'b0;
				fin_q   <= 1'b1;
				fire_q  <= !cb_q;
				cb_q    <= 1'b1;
			end
		end
	end

	// Peer walker and action count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			node_q <= '0;
			sock_q <= '0;
			acnt_q <= '0;
		end else begin
			if (walk_clr) begin
				idx_q  <= '0;
				node_q <= '0;
				sock_q <= '0;
				acnt_q <= '0;
			end else begin
				if (step) begin
					idx_q <= idx_q + 1'b1;
					if (sock_q == 2'(MAX_SOCKETS - 1)) begin
						sock_q <= '0;
						node_q <= node_q + 1'b1;
					end else begin
						sock_q <= sock_q + 1'b1;
					end
				end
				if (emit_act) begin
					acnt_q <= acnt_q + 1'b1;
				end
			end
		end
	end

	// Current request.
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= q_item;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			kind          <= e_kind;
			dest_node     <= e_node;
			dest_socket   <= e_sock;
			exit_id_out   <= e_eid;
			phase         <= (e_kind == KIND_STATUS) ? phase_q : 2'd0;
			close_ready   <= (e_kind == KIND_STATUS) && cr_q;
			finalize_ok   <= (e_kind == KIND_STATUS) && fin_q;
			callback_fire <= (e_kind == KIND_STATUS) && fire_q;
			last          <= (e_kind == KIND_STATUS);
		end
	end

	assign out_valid = ov_q;

	`PEH_AST_NEXT(a_closed_sticky, phase_q == PH_CLOSED, phase_q == PH_CLOSED, "closed phase left")
	`PEH_AST_IMP(a_ready_quiet, cr_q, phase_q == PH_QUIET, "close ready outside quiescing")
	`PEH_AST_IMP(a_action_cap, emit_act, acnt_q < 5'(MAX_ACTIONS), "action cap exceeded")
	`PEH_AST_IMP(a_fire_final, out_valid && callback_fire, finalize_ok && last, "stray callback")
endmodule

// ----- src/peer_exit_handshake.sv -----
// Channel   Direction  Handshake                  Payload
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
// input     in         in_valid / in_stall        mode, peer_node, peer_socket, exit_id_in, now_ms
// result    out        out_valid / out_stall      kind .. last, one item per cycle at most
//
// A start request in the run phase walks every peer slot, one per cycle while the result
// output is free; a pump request in the wait phase walks them too, with an extra compare
// state for a pending peer, whose deadline is read from the retry RAM.
// Reset is asynchronous and active low; it clears all exit state and needs no sweep.
// A stalled result holds the walker; a two-entry queue lets input requests land meanwhile.
module peer_exit_handshake #(
	parameter int MAX_NODES   = peh_pkg::MAX_NODES_DEF,
	parameter int MAX_SOCKETS = peh_pkg::MAX_SOCKETS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [2:0]  peer_node,
	input  logic [1:0]  peer_socket,
	input  logic [31:0] exit_id_in,
	input  logic [63:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [2:0]  dest_node,
	output logic [1:0]  dest_socket,
	output logic [31:0] exit_id_out,
	output logic [1:0]  phase,
	output logic        close_ready,
	output logic        finalize_ok,
	output logic        callback_fire,
	output logic        last
);
	import peh_pkg::*;

	logic [3:0]  node_count_q;
	logic [2:0]  socket_count_q;
	logic [2:0]  own_node_q;
	logic [1:0]  own_socket_q;
	logic [31:0] retry_q, quiesce_q, nonce_q;
	cfg_t        cfg;
	logic        q_valid, q_pop;
	q_item_t     q_item;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= 4'd1;
			socket_count_q <= 3'd1;
			own_node_q     <= '0;
			own_socket_q   <= '0;
			retry_q        <= 32'd1;
			quiesce_q      <= 32'd1;
			nonce_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NODE_COUNT:   node_count_q   <= cfg_data[3:0];
				CFG_SOCKET_COUNT: socket_count_q <= cfg_data[2:0];
				CFG_OWN_NODE:     own_node_q     <= cfg_data[2:0];
				CFG_OWN_SOCKET:   own_socket_q   <= cfg_data[1:0];
				CFG_RETRY:        retry_q        <= cfg_data;
				CFG_QUIESCE:      quiesce_q      <= cfg_data;
				CFG_EXIT_NONCE:   nonce_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective topology and own exit id.
	always_comb begin
		cfg.eff_nodes   = ({1'b0, node_count_q} > 5'(MAX_NODES)) ? 4'(MAX_NODES) : node_count_q;
		cfg.eff_sockets = ({1'b0, socket_count_q} > 4'(MAX_SOCKETS)) ?
			3'(MAX_SOCKETS) : socket_count_q;
		cfg.own_node    = own_node_q;
		cfg.own_socket  = own_socket_q;
		cfg.retry       = retry_q;
		cfg.quiesce     = quiesce_q;
		cfg.own_id      = (nonce_q != 32'd0) ? nonce_q :
			(32'({3'b0, own_node_q} * {3'b0, cfg.eff_sockets}) + 32'(own_socket_q) + 32'd1);
	end

	peh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.peer_node   (peer_node),
		.peer_socket (peer_socket),
		.exit_id_in  (exit_id_in),
		.now_ms      (now_ms),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	peh_back #(
		.MAX_NODES   (MAX_NODES),
		.MAX_SOCKETS (MAX_SOCKETS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.dest_node     (dest_node),
		.dest_socket   (dest_socket),
		.exit_id_out   (exit_id_out),
		.phase         (phase),
		.close_ready   (close_ready),
		.finalize_ok   (finalize_ok),
		.callback_fire (callback_fire),
		.last          (last)
	);
endmodule
